>>> hdl/dlr_pkg.sv
package dlr_pkg;

  // Default geometry of the fixed-point datapath
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Color register
  localparam int                  COLOR_BITS  = 4;
  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 4'd4;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  // Back-end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } back_state_e;

  // Queue status seen by the back end
  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

endpackage

>>> hdl/dda_line_rasterizer_core.sv
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o   command, start_x, start_y, end_x, end_y
// out      source     out_valid_o / out_stall_i pixel_x, pixel_y, pixel_color, pixel_valid,
//                                               last_pixel
// cfg      sink       cfg_valid_i / cfg_ready_o draw_color
//
// A next beat is taken in ST_IDLE without the divider. A load emits its first pixel; for a
// nonzero step count both restoring divider lanes then run in ST_DIV before the next take.
// A two-entry queue parts the input from the back end; the output register holds a
// stalled beat while the back end waits. Reset clears the sequencer, the queue and the
// line state, and sets draw_color to 4. cfg_ready_o is always high.
module dda_line_rasterizer_core
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic        [COLOR_BITS-1:0] pixel_color_o,
  output logic                         pixel_valid_o,
  output logic                         last_pixel_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic        [COLOR_BITS-1:0] cfg_data_i
);

  localparam int EW = 5 * COORD_BITS + 3;

  logic [COLOR_BITS-1:0] color_q;

  logic                  f_cmd;
  logic [COORD_BITS-1:0] f_abs_x;
  logic [COORD_BITS-1:0] f_abs_y;
  logic                  f_neg_x;
  logic                  f_neg_y;
  logic [COORD_BITS-1:0] f_steps;

  logic [EW-1:0]         q_wdata;
  logic [EW-1:0]         q_rdata;
  logic                  q_pop;
  queue_flags_t          q_flags;

  logic                  b_cmd;
  logic [COORD_BITS-1:0] b_sx;
  logic [COORD_BITS-1:0] b_sy;
  logic [COORD_BITS-1:0] b_abs_x;
  logic [COORD_BITS-1:0] b_abs_y;
  logic                  b_neg_x;
  logic                  b_neg_y;
  logic [COORD_BITS-1:0] b_steps;

  // Hold the color register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= cfg_data_i;
    end
  end

  dlr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .command_i(command_i),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i  (end_x_i),
    .end_y_i  (end_y_i),
    .cmd_o    (f_cmd),
    .abs_x_o  (f_abs_x),
    .abs_y_o  (f_abs_y),
    .neg_x_o  (f_neg_x),
    .neg_y_o  (f_neg_y),
    .steps_o  (f_steps)
  );

  // Pack classified beats for the queue
  assign q_wdata    = {f_cmd, start_x_i, start_y_i, f_abs_x, f_abs_y, f_neg_x, f_neg_y, f_steps};
  assign in_stall_o = q_flags.full;

  dlr_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .flags_o(q_flags)
  );

  assign {b_cmd, b_sx, b_sy, b_abs_x, b_abs_y, b_neg_x, b_neg_y, b_steps} = q_rdata;

  dlr_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .color_i      (color_q),
    .q_flags_i    (q_flags),
    .cmd_i        (b_cmd),
    .start_x_i    (b_sx),
    .start_y_i    (b_sy),
    .abs_x_i      (b_abs_x),
    .abs_y_i      (b_abs_y),
    .neg_x_i      (b_neg_x),
    .neg_y_i      (b_neg_y),
    .steps_i      (b_steps),
    .pop_o        (q_pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .pixel_valid_o(pixel_valid_o),
    .last_pixel_o (last_pixel_o)
  );

  // The back end never overwrites a stalled output beat
  a_no_pop_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !q_pop)
    else $error("queue popped while output beat was stalled");

  // Pops only come from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_flags.empty)
    else $error("pop from empty queue");

  // An idle result carries all-zero fields
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |->
      (pixel_x_o == '0) && (pixel_y_o == '0) && (pixel_color_o == '0) && !last_pixel_o)
    else $error("idle result with nonzero fields");

  // A popped beat shows up on the output in the next cycle
  a_pop_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("popped beat did not reach the output");

endmodule

>>> hdl/dlr_front.sv
module dlr_front
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         command_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         cmd_o,
  output logic        [COORD_BITS-1:0] abs_x_o,
  output logic        [COORD_BITS-1:0] abs_y_o,
  output logic                         neg_x_o,
  output logic                         neg_y_o,
  output logic        [COORD_BITS-1:0] steps_o
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic        [COORD_BITS:0] mag_x;
  logic        [COORD_BITS:0] mag_y;

  // Form the per-axis deltas one bit wider than the coordinates
  assign dx = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dy = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};

  // Split each delta into sign and magnitude
  assign neg_x_o = dx[COORD_BITS];
  assign neg_y_o = dy[COORD_BITS];
  assign mag_x   = neg_x_o ? (~dx + 1'b1) : dx;
  assign mag_y   = neg_y_o ? (~dy + 1'b1) : dy;
  assign abs_x_o = mag_x[COORD_BITS-1:0];
  assign abs_y_o = mag_y[COORD_BITS-1:0];

  // Step count is the major-axis length
  assign steps_o = (abs_x_o > abs_y_o) ? abs_x_o : abs_y_o;
  assign cmd_o   = command_i;

endmodule

>>> hdl/dlr_queue.sv
module dlr_queue
  import dlr_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output queue_flags_t     flags_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push;
  logic             do_pop;

  assign flags_o.full  = (count_q == 2'd2);
  assign flags_o.empty = (count_q == 2'd0);
  assign do_push       = push_i && !flags_o.full;
  assign do_pop        = pop_i && !flags_o.empty;
  assign data_o        = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> hdl/dlr_div_lane.sv
module dlr_div_lane
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            start_i,
  input  logic                            step_i,
  input  logic [COORD_BITS+FRAC_BITS-1:0] num_i,
  input  logic [COORD_BITS-1:0]           den_i,
  output logic [FRAC_BITS:0]              quo_o
);

  logic [COORD_BITS-1:0] rem_q;
  logic [FRAC_BITS:0]    shf_q;
  logic [COORD_BITS-1:0] den_q;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  fits;

  // One restoring step: shift in the next numerator bit, try the subtract
  assign trial = {rem_q, shf_q[FRAC_BITS]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});
  assign quo_o = shf_q;

  // Seed with the numerator high part (always below the divisor), then iterate
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[COORD_BITS+FRAC_BITS-1:FRAC_BITS+1]};
      shf_q <= num_i[FRAC_BITS:0];
      den_q <= den_i;
    end else if (step_i) begin
      rem_q <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      shf_q <= {shf_q[FRAC_BITS-1:0], fits};
    end
  end

endmodule

>>> hdl/dlr_back.sv
module dlr_back
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic        [COLOR_BITS-1:0] color_i,
  input  queue_flags_t                 q_flags_i,
  input  logic                         cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic        [COORD_BITS-1:0] abs_x_i,
  input  logic        [COORD_BITS-1:0] abs_y_i,
  input  logic                         neg_x_i,
  input  logic                         neg_y_i,
  input  logic        [COORD_BITS-1:0] steps_i,
  output logic                         pop_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic        [COLOR_BITS-1:0] pixel_color_o,
  output logic                         pixel_valid_o,
  output logic                         last_pixel_o
);

  localparam int PW    = COORD_BITS + FRAC_BITS;
  localparam int IW    = FRAC_BITS + 2;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]      cnt_q;
  logic [COORD_BITS-1:0] left_q;
  logic                  active_q;
  logic                  out_valid_q;
  logic signed [PW-1:0]  pos_x_q;
  logic signed [PW-1:0]  pos_y_q;
  logic        [COORD_BITS-1:0] px_q;
  logic        [COORD_BITS-1:0] py_q;
  logic        [COLOR_BITS-1:0] color_q;
  logic                  pvalid_q;
  logic                  last_q;
  logic                  sign_x_q;
  logic                  sign_y_q;

  logic                  take;
  logic                  is_load;
  logic                  steps_nz;
  logic                  div_start;
  logic                  div_step;
  logic [PW-1:0]         num_x;
  logic [PW-1:0]         num_y;
  logic [FRAC_BITS:0]    quo_x;
  logic [FRAC_BITS:0]    quo_y;
  logic [IW-1:0]         inc_x;
  logic [IW-1:0]         inc_y;
  logic [PW-1:0]         pos_x_nxt;
  logic [PW-1:0]         pos_y_nxt;
  logic [COORD_BITS-1:0] left_dec;

  // Saturating add of an increment to a position
  function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] pos,
                                            input logic [IW-1:0] inc);
    logic [PW:0] sum;
    sum = {pos[PW-1], pos} + {{(PW + 1 - IW){inc[IW-1]}}, inc};
    if (sum[PW] != sum[PW-1]) begin
      sat_add = sum[PW] ? {1'b1, {(PW - 1){1'b0}}} : {1'b0, {(PW - 1){1'b1}}};
    end else begin
      sat_add = sum[PW-1:0];
    end
  endfunction

  // Integer part of a position, truncated toward zero
  function automatic logic [COORD_BITS-1:0] trunc_coord(input logic [PW-1:0] pos);
    logic [PW-1:0] adj;
    adj = pos[PW-1] ? (pos + {{COORD_BITS{1'b0}}, {FRAC_BITS{1'b1}}}) : pos;
    trunc_coord = adj[PW-1:FRAC_BITS];
  endfunction

  assign is_load  = (cmd_i == CMD_LOAD);
  assign steps_nz = (steps_i != '0);

  // Rounded numerators: |d| * 2^F + steps / 2
  assign num_x = {abs_x_i, {FRAC_BITS{1'b0}}} + {{(FRAC_BITS + 1){1'b0}}, steps_i[COORD_BITS-1:1]};
  assign num_y = {abs_y_i, {FRAC_BITS{1'b0}}} + {{(FRAC_BITS + 1){1'b0}}, steps_i[COORD_BITS-1:1]};

  dlr_div_lane #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_x (
    .clk_i  (clk_i),
    .start_i(div_start),
    .step_i (div_step),
    .num_i  (num_x),
    .den_i  (steps_i),
    .quo_o  (quo_x)
  );

  dlr_div_lane #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_y (
    .clk_i  (clk_i),
    .start_i(div_start),
    .step_i (div_step),
    .num_i  (num_y),
    .den_i  (steps_i),
    .quo_o  (quo_y)
  );

  // Apply the delta signs to the quotients
  assign inc_x = sign_x_q ? (~{1'b0, quo_x} + 1'b1) : {1'b0, quo_x};
  assign inc_y = sign_y_q ? (~{1'b0, quo_y} + 1'b1) : {1'b0, quo_y};

  assign pos_x_nxt = sat_add(pos_x_q, inc_x);
  assign pos_y_nxt = sat_add(pos_y_q, inc_y);
  assign left_dec  = left_q - 1'b1;

  // Sequencer outputs
  always_comb begin
    take      = (state_q == ST_IDLE) && !q_flags_i.empty && (!out_valid_q || !out_stall_i);
    pop_o     = take;
    div_start = take && is_load && steps_nz;
    div_step  = (state_q == ST_DIV);
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (div_start) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      left_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) begin
        cnt_q <= CNT_W'(FRAC_BITS);
      end else if (div_step && (cnt_q != '0)) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (take) begin
        if (is_load) begin
          left_q   <= steps_i;
          active_q <= steps_nz;
        end else if (active_q) begin
          left_q   <= left_dec;
          active_q <= (left_dec != '0);
        end
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Positions and the output beat
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (is_load) begin
        pos_x_q  <= {start_x_i, {FRAC_BITS{1'b0}}};
        pos_y_q  <= {start_y_i, {FRAC_BITS{1'b0}}};
        sign_x_q <= neg_x_i;
        sign_y_q <= neg_y_i;
        px_q     <= start_x_i;
        py_q     <= start_y_i;
        color_q  <= color_i;
        pvalid_q <= 1'b1;
        last_q   <= !steps_nz;
      end else if (active_q) begin
        pos_x_q  <= pos_x_nxt;
        pos_y_q  <= pos_y_nxt;
        px_q     <= trunc_coord(pos_x_nxt);
        py_q     <= trunc_coord(pos_y_nxt);
        color_q  <= color_i;
        pvalid_q <= 1'b1;
        last_q   <= (left_dec == '0);
      end else begin
        px_q     <= '0;
        py_q     <= '0;
        color_q  <= '0;
        pvalid_q <= 1'b0;
        last_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = color_q;
  assign pixel_valid_o = pvalid_q;
  assign last_pixel_o  = last_q;

endmodule
